// ----- sv/annexb_nal_unit_extractor_top_assert.svh -----
// ----------------------------------------------------------------------------
// Annex B extractor assertion macros
// Shared helpers for the concurrent checks on the extractor ports.
// ----------------------------------------------------------------------------
`ifndef ANNEXB_NAL_UNIT_EXTRACTOR_TOP_ASSERT_SVH
`define ANNEXB_NAL_UNIT_EXTRACTOR_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk_i and quiet during reset.
`define ANX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and quiet during reset.
`define ANX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/anx_pkg.sv -----
// ----------------------------------------------------------------------------
// Annex B extractor package
// Widths, phase and result codes, and the types shared by the extractor.
// ----------------------------------------------------------------------------
package anx_pkg;

  localparam int LENGTH_BITS     = 24;
  localparam int ZERO_COUNT_BITS = 16;

  // Field widths of one result beat.
  localparam int UNIT_LENGTH_W = 24;
  localparam int ZERO_FIELD_W  = 16;

  // A single byte causes at most four results.
  localparam int MAX_RESULTS = 4;
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Parser phases.
  localparam logic [1:0] PH_SEEK    = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_TRAIL   = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Byte values that matter to start code detection.
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_START = 8'h01;
  localparam logic [7:0] BYTE_STOP  = 8'h02;

  // Zero counts: two zeros form a short prefix, three a long one.
  localparam logic [1:0] PREFIX_ZEROS = 2'd2;
  localparam logic [1:0] LONG_ZEROS   = 2'd3;

  localparam logic [LENGTH_BITS-1:0]     LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [ZERO_COUNT_BITS-1:0] ZC_MAX  = {ZERO_COUNT_BITS{1'b1}};

  typedef struct packed {
    logic [1:0]                 phase;
    logic [7:0]                 win0;
    logic [7:0]                 win1;
    logic [1:0]                 fill;
    logic [1:0]                 run;
    logic [ZERO_COUNT_BITS-1:0] lead;
    logic                       zb;
    logic [LENGTH_BITS-1:0]     count;
    logic [ZERO_COUNT_BITS-1:0] trail;
  } anx_state_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic [7:0]               payload_byte;
    logic [UNIT_LENGTH_W-1:0] unit_length;
    logic [ZERO_FIELD_W-1:0]  leading_zeros;
    logic                     has_zero_byte;
    logic [ZERO_FIELD_W-1:0]  trailing_zeros;
    logic                     stream_done;
  } anx_result_t;

  typedef struct packed {
    anx_result_t [MAX_RESULTS-1:0] item;
    logic [RES_CNT_W-1:0]          count;
  } anx_step_res_t;

endpackage

// ----- sv/anx_if.sv -----
// ----------------------------------------------------------------------------
// Annex B extractor channels
// Valid/ready interfaces for the byte input and the result output.
// ----------------------------------------------------------------------------
interface anx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       end_of_stream;

  modport source (output valid, output stream_byte, output end_of_stream, input ready);
  modport sink   (input valid, input stream_byte, input end_of_stream, output ready);
  modport monitor (input valid, input stream_byte, input end_of_stream, input ready);
endinterface

interface anx_out_if;
  import anx_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               result_kind;
  logic [7:0]               payload_byte;
  logic [UNIT_LENGTH_W-1:0] unit_length;
  logic [ZERO_FIELD_W-1:0]  leading_zeros;
  logic                     has_zero_byte;
  logic [ZERO_FIELD_W-1:0]  trailing_zeros;
  logic                     stream_done;
  logic                     last_result;

  modport source (output valid, output result_kind, output payload_byte,
                  output unit_length, output leading_zeros, output has_zero_byte,
                  output trailing_zeros, output stream_done, output last_result,
                  input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input unit_length, input leading_zeros, input has_zero_byte,
                  input trailing_zeros, input stream_done, input last_result,
                  output ready);
  modport monitor (input valid, input result_kind, input payload_byte,
                   input unit_length, input leading_zeros, input has_zero_byte,
                   input trailing_zeros, input stream_done, input last_result,
                   input ready);
endinterface

// ----- sv/anx_step.sv -----
// ----------------------------------------------------------------------------
// Annex B extractor step logic
// Next parser state and the list of results caused by one stream byte.
// ----------------------------------------------------------------------------
module anx_step import anx_pkg::*; (
  input  anx_state_t    state_i,
  input  logic [7:0]    byte_i,
  input  logic          eos_i,
  output anx_state_t    state_o,
  output anx_step_res_t res_o
);

  function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] v);
    len_inc = (v == LEN_MAX) ? v : v + LENGTH_BITS'(1);
  endfunction

  function automatic logic [ZERO_COUNT_BITS-1:0] zc_inc(
    input logic [ZERO_COUNT_BITS-1:0] v
  );
    zc_inc = (v == ZC_MAX) ? v : v + ZERO_COUNT_BITS'(1);
  endfunction

  function automatic anx_result_t mk_payload(input logic [7:0] b);
    anx_result_t r;
    r              = '0;
    r.kind         = KIND_PAYLOAD;
    r.payload_byte = b;
    mk_payload     = r;
  endfunction

  function automatic anx_result_t mk_summary(input anx_state_t s, input logic done);
    anx_result_t r;
    r                = '0;
    r.kind           = KIND_SUMMARY;
    r.unit_length    = UNIT_LENGTH_W'(s.count);
    r.leading_zeros  = ZERO_FIELD_W'(s.lead);
    r.has_zero_byte  = s.zb;
    r.trailing_zeros = ZERO_FIELD_W'(s.trail);
    r.stream_done    = done;
    mk_summary       = r;
  endfunction

  function automatic anx_result_t mk_error();
    anx_result_t r;
    r        = '0;
    r.kind   = KIND_ERROR;
    mk_error = r;
  endfunction

  function automatic anx_state_t begin_unit(input logic [ZERO_COUNT_BITS-1:0] lead,
                                            input logic zb);
    anx_state_t s;
    s          = '0;
    s.phase    = PH_PAYLOAD;
    s.lead     = lead;
    s.zb       = zb;
    begin_unit = s;
  endfunction

  anx_state_t                  s;
  anx_result_t [MAX_RESULTS-1:0] res;
  logic [RES_CNT_W-1:0]        n;
  logic                        do_trail;
  logic [ZERO_COUNT_BITS:0]    tsum;

  always_comb begin
    s        = state_i;
    res      = '0;
    n        = '0;
    do_trail = 1'b0;
    tsum     = '0;

    case (s.phase)
      PH_SEEK: begin
        if (byte_i == BYTE_ZERO) begin
          if (s.run == LONG_ZEROS) begin
            s.lead = zc_inc(s.lead);
          end else begin
            s.run = s.run + 2'd1;
          end
        end else if (byte_i == BYTE_START && s.run >= PREFIX_ZEROS) begin
          s = begin_unit(s.lead, s.run == LONG_ZEROS);
        end else begin
          res[n[RES_IDX_W-1:0]] = mk_error();
          n = n + RES_CNT_W'(1);
          s = '0;
        end
      end
      PH_PAYLOAD: begin
        if (s.fill < PREFIX_ZEROS) begin
          if (s.fill == 2'd0) begin
            s.win0 = byte_i;
          end else begin
            s.win1 = byte_i;
          end
          s.fill = s.fill + 2'd1;
        end else if (s.win0 == BYTE_ZERO && s.win1 == BYTE_ZERO && byte_i <= BYTE_STOP) begin
          // Window shows 000000, a start code or a stop pattern: the unit ends here.
          s.win0   = '0;
          s.win1   = '0;
          s.phase  = PH_TRAIL;
          s.fill   = PREFIX_ZEROS;
          do_trail = 1'b1;
        end else begin
          res[n[RES_IDX_W-1:0]] = mk_payload(s.win0);
          n       = n + RES_CNT_W'(1);
          s.count = len_inc(s.count);
          s.win0  = s.win1;
          s.win1  = byte_i;
          s.fill  = PREFIX_ZEROS;
        end
      end
      PH_TRAIL: begin
        do_trail = 1'b1;
      end
      default: begin
        s = '0;
      end
    endcase

    if (do_trail) begin
      if (byte_i == BYTE_ZERO) begin
        if (s.fill == LONG_ZEROS) begin
          s.trail = zc_inc(s.trail);
        end else begin
          s.fill = s.fill + 2'd1;
        end
      end else if (byte_i == BYTE_START && s.fill >= PREFIX_ZEROS) begin
        res[n[RES_IDX_W-1:0]] = mk_summary(s, 1'b0);
        n = n + RES_CNT_W'(1);
        s = begin_unit('0, s.fill == LONG_ZEROS);
      end else begin
        res[n[RES_IDX_W-1:0]] = mk_error();
        n = n + RES_CNT_W'(1);
        s = '0;
      end
    end

    if (eos_i) begin
      if (s.phase == PH_PAYLOAD) begin
        // Flush the undecided bytes, then close the unit.
        if (s.fill >= 2'd1) begin
          res[n[RES_IDX_W-1:0]] = mk_payload(s.win0);
          n       = n + RES_CNT_W'(1);
          s.count = len_inc(s.count);
        end
        if (s.fill >= PREFIX_ZEROS) begin
          res[n[RES_IDX_W-1:0]] = mk_payload(s.win1);
          n       = n + RES_CNT_W'(1);
          s.count = len_inc(s.count);
        end
        res[n[RES_IDX_W-1:0]] = mk_summary(s, 1'b1);
        n = n + RES_CNT_W'(1);
      end else if (s.phase == PH_TRAIL) begin
        // Pending zeros can no longer open a start code.
        tsum    = {1'b0, s.trail} + (ZERO_COUNT_BITS + 1)'(s.fill);
        s.trail = tsum[ZERO_COUNT_BITS] ? ZC_MAX : tsum[ZERO_COUNT_BITS-1:0];
        res[n[RES_IDX_W-1:0]] = mk_summary(s, 1'b1);
        n = n + RES_CNT_W'(1);
      end
      s = '0;
    end

    state_o     = s;
    res_o.item  = res;
    res_o.count = n;
  end

endmodule

// ----- sv/anx_outbuf.sv -----
// ----------------------------------------------------------------------------
// Annex B extractor result buffer
// Holds the results of one byte and hands them out one beat at a time.
// ----------------------------------------------------------------------------
module anx_outbuf import anx_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  anx_step_res_t step_i,
  output logic          free_o,
  anx_out_if.source     out_o
);

  anx_result_t [MAX_RESULTS-1:0] entry_q;
  logic [RES_IDX_W-1:0]          rd_q, rd_d;
  logic [RES_CNT_W-1:0]          rem_q, rem_d;
  anx_result_t                   cur;
  logic                          take;

  assign take   = out_o.valid && out_o.ready;
  assign free_o = (rem_q == '0) || (rem_q == RES_CNT_W'(1) && out_o.ready);
  assign cur    = entry_q[rd_q];

  always_comb begin
    rd_d  = rd_q;
    rem_d = rem_q;
    if (load_i) begin
      rd_d  = '0;
      rem_d = step_i.count;
    end else if (take) begin
      rd_d  = rd_q + RES_IDX_W'(1);
      rem_d = rem_q - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      rem_q <= '0;
    end else begin
      rd_q  <= rd_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      entry_q <= step_i.item;
    end
  end

  assign out_o.valid          = (rem_q != '0);
  assign out_o.result_kind    = cur.kind;
  assign out_o.payload_byte   = cur.payload_byte;
  assign out_o.unit_length    = cur.unit_length;
  assign out_o.leading_zeros  = cur.leading_zeros;
  assign out_o.has_zero_byte  = cur.has_zero_byte;
  assign out_o.trailing_zeros = cur.trailing_zeros;
  assign out_o.stream_done    = cur.stream_done;
  assign out_o.last_result    = (rem_q == RES_CNT_W'(1));

endmodule

// ----- sv/annexb_nal_unit_extractor_top.sv -----
// ----------------------------------------------------------------------------
// Annex B NAL unit extractor
// Splits a start-code delimited byte stream into payload beats and summaries.
// ----------------------------------------------------------------------------
// An accepted beat waits in the input register until its results are loaded
// into the result buffer. Throughput: one byte per cycle while each byte
// causes at most one result and the receiver is ready; a byte causing k
// results holds the result buffer for k output beats.
// Reset: rst_ni clears the parser state to the seek phase and empties both
// the input register and the result buffer; no clearing pass is needed.
// ----------------------------------------------------------------------------
module annexb_nal_unit_extractor_top import anx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  anx_in_if.sink    in_i,
  anx_out_if.source out_o
);

  // The input register holds one accepted beat until the result buffer can
  // take the results that it causes. The parser state advances in the same
  // cycle that those results are loaded, so state and results stay in step.
  logic          s1_valid_q;
  logic [7:0]    s1_byte_q;
  logic          s1_eos_q;

  anx_state_t    state_q, state_d;
  anx_step_res_t step_res;
  logic          buf_free;
  logic          advance;

  // The buffer is free when empty or when its final beat leaves this cycle,
  // so a steady payload stream moves one byte per cycle if out_o.ready holds.
  assign advance    = s1_valid_q && buf_free;
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.stream_byte;
      s1_eos_q  <= in_i.end_of_stream;
    end
  end

  // Parser state: phase, lookahead window and the current unit's counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // All per-byte decisions live in one short combinational step.
  anx_step u_step (
    .state_i (state_q),
    .byte_i  (s1_byte_q),
    .eos_i   (s1_eos_q),
    .state_o (state_d),
    .res_o   (step_res)
  );

  // Results of one byte, drained one beat per cycle while out_o.ready is
  // high; a byte with no result simply loads an empty list.
  anx_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance),
    .step_i (step_res),
    .free_o (buf_free),
    .out_o  (out_o)
  );

endmodule

// ----- sv/anx_checker.sv -----
// ----------------------------------------------------------------------------
// Annex B extractor port checker
// Concurrent checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "annexb_nal_unit_extractor_top_assert.svh"

module anx_checker import anx_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [1:0]               out_kind_i,
  input logic [7:0]               out_byte_i,
  input logic [UNIT_LENGTH_W-1:0] out_length_i,
  input logic [ZERO_FIELD_W-1:0]  out_lead_i,
  input logic                     out_zb_i,
  input logic [ZERO_FIELD_W-1:0]  out_trail_i,
  input logic                     out_done_i,
  input logic                     out_last_i
);

  logic stalled;
  logic payload_beat;
  logic done_beat;
  logic error_beat;
  logic payload_clean;
  logic done_ok;
  logic error_ok;
  logic [UNIT_LENGTH_W+2*ZERO_FIELD_W+13:0] beat_view;

  assign stalled       = out_valid_i && !out_ready_i;
  assign payload_beat  = out_valid_i && out_kind_i == KIND_PAYLOAD;
  assign done_beat     = out_valid_i && out_done_i;
  assign error_beat    = out_valid_i && out_kind_i == KIND_ERROR;
  assign payload_clean = out_length_i == '0 && out_lead_i == '0 && out_trail_i == '0 &&
                         !out_zb_i && !out_done_i;
  assign done_ok       = out_last_i && out_kind_i == KIND_SUMMARY;
  assign error_ok      = out_last_i && out_byte_i == '0;
  assign beat_view     = {out_kind_i, out_byte_i, out_length_i, out_lead_i, out_zb_i,
                          out_trail_i, out_done_i, out_last_i};

  // A stalled beat keeps its contents.
  `ANX_ASSERT_NXT(a_out_hold, stalled, out_valid_i && $stable(beat_view), "result beat changed while stalled")

  // Payload beats carry no unit statistics.
  `ANX_ASSERT_IMP(a_payload_clean, payload_beat, payload_clean, "payload beat with summary fields set")

  // The end-of-stream summary closes the byte's results.
  `ANX_ASSERT_IMP(a_done_last, done_beat, done_ok, "stream_done not on final summary")

  // An error always ends the byte's results.
  `ANX_ASSERT_IMP(a_error_last, error_beat, error_ok, "error beat not last")

endmodule

bind annexb_nal_unit_extractor_top anx_checker u_anx_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_kind_i   (out_o.result_kind),
  .out_byte_i   (out_o.payload_byte),
  .out_length_i (out_o.unit_length),
  .out_lead_i   (out_o.leading_zeros),
  .out_zb_i     (out_o.has_zero_byte),
  .out_trail_i  (out_o.trailing_zeros),
  .out_done_i   (out_o.stream_done),
  .out_last_i   (out_o.last_result)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Annex B NAL unit extractor testbench
// Drives a directed table and then random start-code streams into the block.
// Every accepted byte is also run through a behavioral parser in the bench,
// and each output beat is compared field by field with the oldest beat
// still expected.
// ----------------------------------------------------------------------------
module tb;
  import anx_pkg::*;

  // Cycles without any accepted beat, on either side, before the run gives up.
  localparam int unsigned STALL_LIMIT = 1000;
  // Cycles allowed after the last expected beat for anything stray to appear.
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_ITEMS = 320;

  // How a stimulus row is checked: by the parser, or by a result typed in.
  typedef enum logic [1:0] {
    ROW_PREDICT   = 2'd0,
    ROW_NO_RESULT = 2'd1,
    ROW_ERROR     = 2'd2
  } row_check_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_stream;
    row_check_e check;
  } stim_row_t;

  // One output beat as the bench expects it.
  typedef struct packed {
    logic [1:0]               kind;
    logic [7:0]               pbyte;
    logic [UNIT_LENGTH_W-1:0] len;
    logic [ZERO_FIELD_W-1:0]  lead;
    logic                     zb;
    logic [ZERO_FIELD_W-1:0]  trail;
    logic                     done;
    logic                     last;
  } nal_beat_t;

  logic clk_i;
  logic rst_ni;

  anx_in_if  in_if ();
  anx_out_if out_if ();

  annexb_nal_unit_extractor_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Directed table. Rows whose outcome is obvious carry it directly (an error
  // beat, or nothing at all); the rest are left to the parser below.
  // --------------------------------------------------------------------------
  stim_row_t dir_rows [27] = '{
    '{8'h05, 1'b0, ROW_ERROR},      // Stray byte while hunting for a start code.
    '{8'h01, 1'b0, ROW_ERROR},      // 0x01 with too few zeros in front of it.
    '{8'h00, 1'b0, ROW_NO_RESULT},
    '{8'h00, 1'b0, ROW_NO_RESULT},
    '{8'h00, 1'b1, ROW_NO_RESULT},  // Stream ends during the hunt: zeros dropped.
    '{8'h00, 1'b0, ROW_NO_RESULT},
    '{8'h00, 1'b0, ROW_NO_RESULT},
    '{8'h00, 1'b0, ROW_NO_RESULT},
    '{8'h00, 1'b0, ROW_NO_RESULT},  // Fourth zero is a leading zero.
    '{8'h01, 1'b0, ROW_NO_RESULT},  // Long start code opens a unit.
    '{8'hFF, 1'b0, ROW_NO_RESULT},
    '{8'h00, 1'b0, ROW_NO_RESULT},
    '{8'h00, 1'b0, ROW_PREDICT},    // Window full: 0xFF leaves as payload.
    '{8'h02, 1'b0, ROW_ERROR},      // 000002 ends the payload and is rejected.
    '{8'h00, 1'b0, ROW_NO_RESULT},
    '{8'h00, 1'b0, ROW_NO_RESULT},
    '{8'h01, 1'b0, ROW_NO_RESULT},  // Short start code.
    '{8'h80, 1'b0, ROW_NO_RESULT},
    '{8'h00, 1'b0, ROW_NO_RESULT},
    '{8'h00, 1'b0, ROW_PREDICT},
    '{8'h00, 1'b0, ROW_PREDICT},    // 000000 moves the parser to trailing zeros.
    '{8'h00, 1'b0, ROW_PREDICT},
    '{8'h01, 1'b0, ROW_PREDICT},    // Next start code: summary, new unit at once.
    '{8'h7E, 1'b1, ROW_PREDICT},    // Stream ends in payload: window flushed.
    '{8'h00, 1'b0, ROW_NO_RESULT},
    '{8'h00, 1'b0, ROW_NO_RESULT},
    '{8'h01, 1'b1, ROW_PREDICT}     // Stream ends right after a start code.
  };

  stim_row_t byte_q[$];
  nal_beat_t expected_beats[$];
  nal_beat_t step_beats[$];
  int unsigned fail_cnt = 0;
  int unsigned stall_cycles = 0;

  // --------------------------------------------------------------------------
  // Behavioral parser. It mirrors the block's seek, payload and trailing
  // phases and collects the beats caused by one byte in step_beats.
  // --------------------------------------------------------------------------
  logic [1:0]                 prs_phase;
  logic [7:0]                 prs_win [3];
  int unsigned                prs_fill;       // Window bytes, or pending zeros in trailing.
  int unsigned                prs_seek_zeros; // Pending zeros while hunting (0..3).
  logic [ZERO_COUNT_BITS-1:0] prs_lead;
  logic                       prs_zb;
  logic [LENGTH_BITS-1:0]     prs_len;
  logic [ZERO_COUNT_BITS-1:0] prs_trail;

  function automatic void push_beat(logic [1:0] kind, logic [7:0] pbyte,
                                    logic [UNIT_LENGTH_W-1:0] len,
                                    logic [ZERO_FIELD_W-1:0] lead, logic zb,
                                    logic [ZERO_FIELD_W-1:0] trail, logic done);
    step_beats.insert(step_beats.size(),
                      '{kind: kind, pbyte: pbyte, len: len, lead: lead, zb: zb,
                        trail: trail, done: done, last: 1'b0});
  endfunction

  function automatic void clear_parser();
    prs_phase      = PH_SEEK;
    prs_win        = '{default: 8'h00};
    prs_fill       = 0;
    prs_seek_zeros = 0;
    prs_lead       = '0;
    prs_zb         = 1'b0;
    prs_len        = '0;
    prs_trail      = '0;
  endfunction

  function automatic void flag_format_error();
    push_beat(KIND_ERROR, '0, '0, '0, 1'b0, '0, 1'b0);
    clear_parser();
  endfunction

  function automatic void push_summary(logic done);
    push_beat(KIND_SUMMARY, '0, prs_len, prs_lead, prs_zb, prs_trail, done);
  endfunction

  // A unit opens with the zeros that preceded its 0x01; three or more of
  // them mean a zero_byte was present.
  function automatic void open_unit(logic [ZERO_COUNT_BITS-1:0] lead,
                                    int unsigned pending);
    prs_phase      = PH_PAYLOAD;
    prs_lead       = lead;
    prs_zb         = (pending >= 3);
    prs_len        = '0;
    prs_trail      = '0;
    prs_fill       = 0;
    prs_seek_zeros = 0;
    prs_win        = '{default: 8'h00};
  endfunction

  function automatic void seek_in(logic [7:0] b);
    if (b == BYTE_ZERO) begin
      if (prs_seek_zeros >= 3) begin
        if (prs_lead < ZC_MAX) prs_lead++;
      end else begin
        prs_seek_zeros++;
      end
    end else if (b == BYTE_START && prs_seek_zeros >= 2) begin
      open_unit(prs_lead, prs_seek_zeros);
    end else begin
      flag_format_error();
    end
  endfunction

  function automatic void trail_in(logic [7:0] b);
    int unsigned pending;
    if (b == BYTE_ZERO) begin
      if (prs_fill >= 3) begin
        if (prs_trail < ZC_MAX) prs_trail++;
      end else begin
        prs_fill++;
      end
    end else if (b == BYTE_START && prs_fill >= 2) begin
      pending = prs_fill;
      push_summary(1'b0);
      open_unit('0, pending);
    end else begin
      flag_format_error();
    end
  endfunction

  function automatic void emit_payload(logic [7:0] b);
    push_beat(KIND_PAYLOAD, b, '0, '0, 1'b0, '0, 1'b0);
    if (prs_len < LEN_MAX) prs_len++;
  endfunction

  // The oldest window byte leaves as payload unless the window reads 000000,
  // 000001 or 000002, which closes the unit.
  function automatic void payload_in(logic [7:0] b);
    int unsigned slot;
    logic [7:0]  third;
    slot = (prs_fill > 2) ? 2 : prs_fill;
    prs_win[slot] = b;
    prs_fill = slot + 1;
    if (prs_fill < 3) return;
    if (prs_win[0] == BYTE_ZERO && prs_win[1] == BYTE_ZERO && prs_win[2] <= BYTE_STOP) begin
      third     = prs_win[2];
      prs_win   = '{default: 8'h00};
      prs_phase = PH_TRAIL;
      prs_fill  = 2;
      trail_in(third);
    end else begin
      emit_payload(prs_win[0]);
      prs_win[0] = prs_win[1];
      prs_win[1] = prs_win[2];
      prs_win[2] = 8'h00;
      prs_fill   = 2;
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic eos);
    int unsigned total;
    step_beats.delete();
    case (prs_phase)
      PH_SEEK:    seek_in(b);
      PH_PAYLOAD: payload_in(b);
      PH_TRAIL:   trail_in(b);
      default:    clear_parser();
    endcase
    if (eos) begin
      if (prs_phase == PH_PAYLOAD) begin
        for (int i = 0; i < ((prs_fill > 3) ? 3 : prs_fill); i++) emit_payload(prs_win[i]);
        push_summary(1'b1);
      end else if (prs_phase == PH_TRAIL) begin
        // Zeros still pending at the end count as trailing zeros.
        total = prs_trail + prs_fill;
        prs_trail = (total > ZC_MAX) ? ZC_MAX : total[ZERO_COUNT_BITS-1:0];
        push_summary(1'b1);
      end
      clear_parser();
    end
    if (step_beats.size() > 0) step_beats[step_beats.size()-1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Random stream builders. Most of the random part is well-formed streams
  // with random payloads, so that units open, close and chain; a share of
  // them break inside, and loose noise bytes fill the rest.
  // --------------------------------------------------------------------------
  function automatic void add_byte(logic [7:0] b, logic eos);
    byte_q.insert(byte_q.size(), '{stream_byte: b, end_of_stream: eos, check: ROW_PREDICT});
  endfunction

  function automatic void add_zeros(int unsigned n);
    repeat (n) add_byte(BYTE_ZERO, 1'b0);
  endfunction

  function automatic void add_start_code();
    add_zeros($urandom_range(2, 3));
    add_byte(BYTE_START, 1'b0);
  endfunction

  // Payload is zero-heavy, but two zeros are never followed by a byte that
  // would close the unit early.
  function automatic void add_payload(int unsigned n);
    int unsigned run;
    logic [7:0]  b;
    run = 0;
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) b = 8'h00;
      else b = 8'($urandom_range(0, 255));
      if (run >= 2 && b <= BYTE_STOP) b = 8'($urandom_range(3, 255));
      run = (b == 8'h00) ? run + 1 : 0;
      add_byte(b, 1'b0);
    end
  endfunction

  function automatic void add_stream();
    int unsigned units;
    units = $urandom_range(1, 4);
    add_zeros($urandom_range(0, 4));
    add_start_code();
    for (int k = 0; k < units; k++) begin
      add_payload(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10));
      if (k < units - 1) begin
        add_zeros($urandom_range(0, 3));
        case ($urandom_range(0, 9))
          0: add_byte(8'($urandom_range(2, 255)), 1'b0);    // Stray byte after the unit.
          1: begin add_zeros(2); add_byte(BYTE_STOP, 1'b0); end
          default: add_start_code();
        endcase
      end
    end
    // The stream ends on payload, on trailing zeros, or on a fresh start code.
    case ($urandom_range(0, 2))
      0: ;
      1: add_zeros($urandom_range(1, 5));
      default: add_start_code();
    endcase
    byte_q[byte_q.size()-1].end_of_stream = 1'b1;
  endfunction

  function automatic void add_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(0, 2));
      else b = 8'($urandom_range(0, 255));
      add_byte(b, $urandom_range(0, 7) == 0);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: the receiver stalls on a pattern that switches periodically
  // between always ready, alternating ready, random and mostly stalled.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned tick;
    int unsigned mode;
    out_if.ready = 1'b0;
    tick = 0;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (tick % 48 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= (tick % 2 == 0);
        2: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= ((tick % 7) < 2);
      endcase
      tick++;
    end
  end

  // Result checker and watchdog. Both sample at the rising edge, before the
  // block's registers move.
  always @(posedge clk_i) begin : check_results
    nal_beat_t want;
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall_cycles = 0;
      else stall_cycles++;
      if (out_if.valid && out_if.ready) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected: kind %0d", out_if.result_kind);
          fail_cnt++;
        end else begin
          want = expected_beats.pop_front();
          check_field("result_kind",    32'(want.kind),  32'(out_if.result_kind));
          check_field("payload_byte",   32'(want.pbyte), 32'(out_if.payload_byte));
          check_field("unit_length",    32'(want.len),   32'(out_if.unit_length));
          check_field("leading_zeros",  32'(want.lead),  32'(out_if.leading_zeros));
          check_field("has_zero_byte",  32'(want.zb),    32'(out_if.has_zero_byte));
          check_field("trailing_zeros", 32'(want.trail), 32'(out_if.trailing_zeros));
          check_field("stream_done",    32'(want.done),  32'(out_if.stream_done));
          check_field("last_result",    32'(want.last),  32'(out_if.last_result));
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("** annexb_nal_unit_extractor_top: FAILED **");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: build the stimulus, reset, then send it in bursts with
  // random gaps, predicting each byte's beats when it is accepted.
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t   cur;
    int unsigned idx;
    int unsigned burst_left;
    int unsigned gap;
    int unsigned random_start;

    rst_ni                = 1'b0;
    in_if.valid           = 1'b0;
    in_if.stream_byte     = 8'h00;
    in_if.end_of_stream   = 1'b0;
    clear_parser();

    foreach (dir_rows[i]) byte_q.insert(byte_q.size(), dir_rows[i]);
    random_start = byte_q.size();
    while (byte_q.size() - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 8) add_stream();
      else add_noise();
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idx = 0;
    burst_left = 0;
    while (idx < byte_q.size()) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      cur = byte_q[idx];
      in_if.valid         <= 1'b1;
      in_if.stream_byte   <= cur.stream_byte;
      in_if.end_of_stream <= cur.end_of_stream;
      do @(posedge clk_i); while (!in_if.ready);

      // The beat is taken: the parser always advances, and the row decides
      // whether its beats or a typed outcome are expected.
      parse_byte(cur.stream_byte, cur.end_of_stream);
      case (cur.check)
        ROW_PREDICT: foreach (step_beats[i]) begin
          expected_beats.insert(expected_beats.size(), step_beats[i]);
        end
        ROW_ERROR: expected_beats.insert(expected_beats.size(),
                                         '{kind: KIND_ERROR, pbyte: '0, len: '0,
                                           lead: '0, zb: 1'b0, trail: '0,
                                           done: 1'b0, last: 1'b1});
        default: ;
      endcase
      idx++;
      burst_left--;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("** annexb_nal_unit_extractor_top: PASSED **");
    end else begin
      $display("** annexb_nal_unit_extractor_top: FAILED **");
    end
    $finish;
  end

endmodule
